>>> sv/hxf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxf_pkg
// Shared types and constants of the hex text report framer.
// ----------------------------------------------------------------------------
package hxf_pkg;

    localparam int           MAX_MESSAGE_BYTES = 127;
    localparam logic [6:0]   MAX_LEN           = 7'(MAX_MESSAGE_BYTES);
    localparam logic [3:0]   REPORT_BYTES      = 4'd15;

    localparam logic [7:0]   HDR_SINGLE        = 8'hC0;
    localparam logic [7:0]   HDR_FIRST         = 8'h8F;
    localparam logic [7:0]   HDR_LAST          = 8'h40;
    localparam logic [7:0]   HDR_MIDDLE        = 8'h0F;

    localparam logic [7:0]   CHAR_DIGIT_LIMIT  = 8'd58;
    localparam logic [7:0]   CHAR_UPPER_LIMIT  = 8'd91;
    localparam logic [7:0]   CHAR_LOWER_LIMIT  = 8'd123;
    localparam logic [7:0]   CHAR_DIGIT_BASE   = 8'd48;
    localparam logic [7:0]   CHAR_UPPER_BASE   = 8'd55;
    localparam logic [7:0]   CHAR_LOWER_BASE   = 8'd87;
    localparam logic [6:0]   SHORT_LIMIT       = 7'd16;

    localparam int           FIFO_DEPTH        = 4;
    localparam int           PTR_W             = $clog2(FIFO_DEPTH);
    localparam int           CNT_W             = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       report_end;
        logic       message_end;
    } t_result;

    typedef struct packed {
        logic    wr0;
        logic    wr1;
        t_result d0;
        t_result d1;
    } t_push;

endpackage

>>> sv/hxf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxf_in_if / hxf_out_if
// Valid/ready channels for hex characters in and framed bytes out.
// ----------------------------------------------------------------------------
interface hxf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] hex_char;
    logic [6:0] message_bytes;

    modport source (output valid, output hex_char, output message_bytes, input ready);
    modport sink   (input valid, input hex_char, input message_bytes, output ready);
endinterface

interface hxf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_header;
    logic       report_end;
    logic       message_end;

    modport source (output valid, output out_byte, output is_header,
                    output report_end, output message_end, input ready);
    modport sink   (input valid, input out_byte, input is_header,
                    input report_end, input message_end, output ready);
endinterface

>>> sv/hex_text_report_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_text_report_framer
// Frames ASCII hex command text into headed reports of up to 15 bytes.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  i_in     in   hex_char[8], message_bytes[7]
//  o_out    out  out_byte[8], is_header, report_end, message_end
//
//  One character is taken per cycle while i_in.ready is high; each pair of
//  characters forms a byte, queued when its second character is taken. A report
//  header adds one extra word, queued in a four-word output FIFO. i_in.ready
//  drops only when the FIFO has fewer than two free slots. Synchronous active-low
//  reset clears framing state and the FIFO.
module hex_text_report_framer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hxf_in_if.sink    i_in,
    hxf_out_if.source o_out
);

    hxf_pkg::t_push   w_push;
    hxf_pkg::t_result w_head;
    logic             w_room;
    logic             w_valid;

    assign i_in.ready = w_room;

    hxf_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (i_in.valid && w_room),
        .i_hex_char      (i_in.hex_char),
        .i_message_bytes (i_in.message_bytes),
        .o_push          (w_push)
    );

    hxf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (o_out.ready),
        .o_room  (w_room),
        .o_valid (w_valid),
        .o_head  (w_head)
    );

    assign o_out.valid       = w_valid;
    assign o_out.out_byte    = w_head.out_byte;
    assign o_out.is_header   = w_head.is_header;
    assign o_out.report_end  = w_head.report_end;
    assign o_out.message_end = w_head.message_end;

endmodule

>>> sv/hxf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxf_core
// Character decode, byte pairing and report framing; a header and a byte can be pushed together.
// ----------------------------------------------------------------------------
module hxf_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_hex_char,
    input  logic [6:0]     i_message_bytes,
    output hxf_pkg::t_push o_push
);

    logic       r_in_message, n_in_message;
    logic [6:0] r_length,     n_length;
    logic       r_low_next,   n_low_next;
    logic [3:0] r_high_hold,  n_high_hold;
    logic [3:0] r_last_digit, n_last_digit;
    logic [6:0] r_bytes_done, n_bytes_done;
    logic [3:0] r_report_pos, n_report_pos;

    logic       w_open;
    logic [6:0] w_mb_sat;
    logic [6:0] w_len;
    logic [6:0] w_bd;
    logic [3:0] w_rp;
    logic       w_low;
    logic [7:0] w_sub;
    logic [3:0] w_nib;
    logic [6:0] w_remaining;
    logic [6:0] w_bd_inc;
    logic [3:0] w_rp_inc;
    logic       w_mend;
    logic       w_rend;
    logic [7:0] w_header;

    always_comb begin
        w_open   = !r_in_message;
        w_mb_sat = (i_message_bytes > hxf_pkg::MAX_LEN) ? hxf_pkg::MAX_LEN : i_message_bytes;
        w_len    = w_open ? w_mb_sat : r_length;
        w_bd     = w_open ? 7'd0 : r_bytes_done;
        w_rp     = w_open ? 4'd0 : r_report_pos;
        w_low    = w_open ? 1'b0 : r_low_next;

        if (i_hex_char < hxf_pkg::CHAR_DIGIT_LIMIT) begin
            w_sub = i_hex_char - hxf_pkg::CHAR_DIGIT_BASE;
        end else if (i_hex_char < hxf_pkg::CHAR_UPPER_LIMIT) begin
            w_sub = i_hex_char - hxf_pkg::CHAR_UPPER_BASE;
        end else begin
            w_sub = i_hex_char - hxf_pkg::CHAR_LOWER_BASE;
        end
        w_nib = (i_hex_char < hxf_pkg::CHAR_LOWER_LIMIT) ? w_sub[3:0] : r_last_digit;

        w_remaining = w_len - w_bd;
        w_bd_inc    = w_bd + 7'd1;
        w_rp_inc    = w_rp + 4'd1;
        w_mend      = (w_bd_inc >= w_len);
        w_rend      = w_mend || (w_rp_inc >= hxf_pkg::REPORT_BYTES);

        if (w_bd == 7'd0) begin
            w_header = (w_remaining < hxf_pkg::SHORT_LIMIT)
                     ? (hxf_pkg::HDR_SINGLE | {1'b0, w_len}) : hxf_pkg::HDR_FIRST;
        end else begin
            w_header = (w_remaining < hxf_pkg::SHORT_LIMIT)
                     ? (hxf_pkg::HDR_LAST | {1'b0, w_remaining}) : hxf_pkg::HDR_MIDDLE;
        end
    end

    // next state and result words
    always_comb begin
        n_in_message = r_in_message;
        n_length     = r_length;
        n_low_next   = r_low_next;
        n_high_hold  = r_high_hold;
        n_last_digit = r_last_digit;
        n_bytes_done = r_bytes_done;
        n_report_pos = r_report_pos;
        o_push       = '0;

        if (i_accept && !(w_open && (i_message_bytes == 7'd0))) begin
            n_in_message = 1'b1;
            n_length     = w_len;
            n_bytes_done = w_bd;
            n_report_pos = w_rp;
            n_last_digit = w_nib;
            if (!w_low) begin
                n_high_hold = w_nib;
                n_low_next  = 1'b1;
            end else begin
                n_low_next   = 1'b0;
                n_bytes_done = w_bd_inc;
                n_report_pos = w_rend ? 4'd0 : w_rp_inc;
                if (w_mend) begin
                    n_in_message = 1'b0;
                    n_bytes_done = 7'd0;
                end
                if (w_rp == 4'd0) begin
                    o_push.wr0                = 1'b1;
                    o_push.d0.out_byte        = w_header;
                    o_push.d0.is_header       = 1'b1;
                    o_push.wr1                = 1'b1;
                    o_push.d1.out_byte        = {r_high_hold, w_nib};
                    o_push.d1.report_end      = w_rend;
                    o_push.d1.message_end     = w_mend;
                end else begin
                    o_push.wr0                = 1'b1;
                    o_push.d0.out_byte        = {r_high_hold, w_nib};
                    o_push.d0.report_end      = w_rend;
                    o_push.d0.message_end     = w_mend;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_message <= 1'b0;
            r_length     <= '0;
            r_low_next   <= 1'b0;
            r_high_hold  <= '0;
            r_last_digit <= '0;
            r_bytes_done <= '0;
            r_report_pos <= '0;
        end else begin
            r_in_message <= n_in_message;
            r_length     <= n_length;
            r_low_next   <= n_low_next;
            r_high_hold  <= n_high_hold;
            r_last_digit <= n_last_digit;
            r_bytes_done <= n_bytes_done;
            r_report_pos <= n_report_pos;
        end
    end

endmodule

>>> sv/hxf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxf_fifo
// Small result queue; takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
module hxf_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hxf_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output hxf_pkg::t_result o_head
);

    hxf_pkg::t_result                r_mem [hxf_pkg::FIFO_DEPTH];
    logic [hxf_pkg::PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [hxf_pkg::PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [hxf_pkg::CNT_W-1:0]       r_count,  n_count;
    logic [hxf_pkg::PTR_W-1:0]       w_wr_ptr1;
    logic [hxf_pkg::CNT_W-1:0]       w_push_n;
    logic                            w_pop;

    assign o_room    = (r_count <= hxf_pkg::CNT_W'(hxf_pkg::FIFO_DEPTH - 2));
    assign o_valid   = (r_count != '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_pop     = i_pop && o_valid;
    assign w_wr_ptr1 = r_wr_ptr + hxf_pkg::PTR_W'(1);
    assign w_push_n  = hxf_pkg::CNT_W'(i_push.wr0) + hxf_pkg::CNT_W'(i_push.wr1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + w_push_n[hxf_pkg::PTR_W-1:0];
        n_rd_ptr = w_pop ? (r_rd_ptr + hxf_pkg::PTR_W'(1)) : r_rd_ptr;
        n_count  = r_count + w_push_n - hxf_pkg::CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.wr0) begin
            r_mem[r_wr_ptr] <= i_push.d0;
        end
        if (i_push.wr1) begin
            r_mem[w_wr_ptr1] <= i_push.d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
